[hdl/rprop_pkg.sv]
package rprop_pkg;

    // Table size and field widths.
    localparam int WEIGHT_COUNT = 1024;
    localparam int INDEX_W      = 10;
    localparam int VALUE_W      = 32;
    localparam int STEP_W       = 31;
    localparam int ETA_W        = 16;
    localparam int ETA_FRAC     = 14;
    localparam int PBAND_W      = 40;
    localparam int PRODUCT_W    = 2 * VALUE_W;
    localparam int SCALED_W     = STEP_W + ETA_W;

    // Only indexes that the index field can reach need storage.
    localparam int MEM_DEPTH = (WEIGHT_COUNT < (1 << INDEX_W)) ? WEIGHT_COUNT : (1 << INDEX_W);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Queue between the front and back parts.
    localparam int QPTR_W      = 2;
    localparam int QUEUE_DEPTH = 1 << QPTR_W;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_UPDATE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        CASE_LOAD = 2'd0,
        CASE_SAME = 2'd1,
        CASE_FLIP = 2'd2,
        CASE_ZERO = 2'd3
    } sign_case_t;

    typedef enum logic [1:0] {
        GS_ZERO = 2'd0,
        GS_POS  = 2'd1,
        GS_NEG  = 2'd2
    } grad_sign_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ETA_INCREASE      = 3'd0,
        CFG_ETA_DECREASE      = 3'd1,
        CFG_STEP_MIN          = 3'd2,
        CFG_STEP_MAX          = 3'd3,
        CFG_INITIAL_STEP      = 3'd4,
        CFG_GRAD_ZERO_BAND    = 3'd5,
        CFG_PRODUCT_ZERO_BAND = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [ETA_W-1:0]   eta_increase;
        logic [ETA_W-1:0]   eta_decrease;
        logic [STEP_W-1:0]  step_min;
        logic [STEP_W-1:0]  step_max;
        logic [STEP_W-1:0]  initial_step;
        logic [STEP_W-1:0]  grad_zero_band;
        logic [PBAND_W-1:0] product_zero_band;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        eta_increase:      16'd19661,
        eta_decrease:      16'd8192,
        step_min:          31'd17,
        step_max:          31'd838860800,
        initial_step:      31'd1677722,
        grad_zero_band:    31'd1,
        product_zero_band: 40'd281475
    };

    // A classified request as it travels from the front part to the back part.
    typedef struct packed {
        opcode_t                     opcode;
        logic [INDEX_W-1:0]          index;
        logic signed [VALUE_W-1:0]   value;
        grad_sign_t                  gsign;
        logic                        in_range;
    } item_t;

endpackage

[hdl/rprop_weight_update_unit.sv]
// Channel   | Signals                                         | Direction
// ----------+-------------------------------------------------+----------
// item      | item_valid/ready, opcode, weight_index,         | in
//           | operand_value                                   |
// result    | result_valid/ready, result_index, new_weight,   | out
//           | weight_change, new_step, sign_case              |
// cfg       | cfg_valid/ready, cfg_index, cfg_data            | in
//
// One request per cycle while results are taken, for requests that address different entries;
// a result is presented after passing six registers (front register, queue, table read,
// multiply, classify, add). The entry table read-modify-write sets the rate: a request whose
// entry is still in one of the three stages ahead waits until that entry is written. Reset
// clears the control state and loads the register defaults; the entry table holds no value
// until an entry is loaded. A stalled result holds the back pipeline; the four-deep queue
// and front register keep accepting requests until they fill.
module rprop_weight_update_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     item_valid,
    output logic                                     item_ready,
    input  logic                                     opcode,
    input  logic [rprop_pkg::INDEX_W-1:0]            weight_index,
    input  logic signed [rprop_pkg::VALUE_W-1:0]     operand_value,
    output logic                                     result_valid,
    input  logic                                     result_ready,
    output logic [rprop_pkg::INDEX_W-1:0]            result_index,
    output logic signed [rprop_pkg::VALUE_W-1:0]     new_weight,
    output logic signed [rprop_pkg::VALUE_W-1:0]     weight_change,
    output logic [rprop_pkg::STEP_W-1:0]             new_step,
    output logic [1:0]                               sign_case,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [rprop_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [rprop_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import rprop_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   push_valid;
    logic   push_ready;
    item_t  push_item;
    logic   pop_valid;
    logic   pop_ready;
    item_t  pop_item;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ETA_INCREASE:      cfg_next.eta_increase      = cfg_data[ETA_W-1:0];
                CFG_ETA_DECREASE:      cfg_next.eta_decrease      = cfg_data[ETA_W-1:0];
                CFG_STEP_MIN:          cfg_next.step_min          = cfg_data[STEP_W-1:0];
                CFG_STEP_MAX:          cfg_next.step_max          = cfg_data[STEP_W-1:0];
                CFG_INITIAL_STEP:      cfg_next.initial_step      = cfg_data[STEP_W-1:0];
                CFG_GRAD_ZERO_BAND:    cfg_next.grad_zero_band    = cfg_data[STEP_W-1:0];
                CFG_PRODUCT_ZERO_BAND: cfg_next.product_zero_band = cfg_data[PBAND_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front part: accepts and classifies requests.
    rprop_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .opcode        (opcode),
        .weight_index  (weight_index),
        .operand_value (operand_value),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    // Queue that lets the two parts stall independently.
    rprop_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back part: table access, update rule and result register.
    rprop_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_index  (result_index),
        .new_weight    (new_weight),
        .weight_change (weight_change),
        .new_step      (new_step),
        .sign_case     (sign_case)
    );

endmodule

[hdl/rprop_front.sv]
module rprop_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rprop_pkg::cfg_t                      cfg,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic                                 opcode,
    input  logic [rprop_pkg::INDEX_W-1:0]        weight_index,
    input  logic signed [rprop_pkg::VALUE_W-1:0] operand_value,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output rprop_pkg::item_t                     push_item
);
    import rprop_pkg::*;

    logic                 front_valid_reg;
    logic                 front_valid_next;
    item_t                front_item_reg;
    item_t                front_item_next;
    logic [VALUE_W-1:0]   grad_mag;
    logic                 accept;

    // A new request enters when the holding register is empty or draining.
    assign item_ready = !front_valid_reg || push_ready;
    assign accept     = item_valid && item_ready;

    // Classify the request: gradient sign with its zero band, and index range.
    assign grad_mag = operand_value[VALUE_W-1] ? VALUE_W'(-operand_value)
                                               : VALUE_W'(operand_value);

    always_comb
    begin
        front_item_next.opcode   = opcode_t'(opcode);
        front_item_next.index    = weight_index;
        front_item_next.value    = operand_value;
        front_item_next.in_range = int'(weight_index) < WEIGHT_COUNT;
        if (grad_mag < {1'b0, cfg.grad_zero_band})
        begin
            front_item_next.gsign = GS_ZERO;
        end
        else if (operand_value > 0)
        begin
            front_item_next.gsign = GS_POS;
        end
        else
        begin
            // Outside the band, a gradient that is not positive counts as negative.
            front_item_next.gsign = GS_NEG;
        end
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_item_reg <= front_item_next;
        end
    end

    assign push_valid = front_valid_reg;
    assign push_item  = front_item_reg;

endmodule

[hdl/rprop_queue.sv]
module rprop_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  rprop_pkg::item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output rprop_pkg::item_t pop_item
);
    import rprop_pkg::*;

    item_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hdl/rprop_back.sv]
module rprop_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rprop_pkg::cfg_t                      cfg,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  rprop_pkg::item_t                     pop_item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [rprop_pkg::INDEX_W-1:0]        result_index,
    output logic signed [rprop_pkg::VALUE_W-1:0] new_weight,
    output logic signed [rprop_pkg::VALUE_W-1:0] weight_change,
    output logic [rprop_pkg::STEP_W-1:0]         new_step,
    output logic [1:0]                           sign_case
);
    import rprop_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0] weight;
        logic [STEP_W-1:0]         step;
        logic signed [VALUE_W-1:0] prior_grad;
        logic signed [VALUE_W-1:0] prior_change;
    } entry_t;

    typedef struct packed {
        item_t                       item;
        logic signed [VALUE_W-1:0]   weight;
        logic [STEP_W-1:0]           step;
        logic signed [VALUE_W-1:0]   prior_change;
        logic signed [PRODUCT_W-1:0] product;
        logic [SCALED_W-1:0]         inc_prod;
        logic [SCALED_W-1:0]         dec_prod;
    } mul_stage_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic [INDEX_W-1:0]        index;
        logic                      in_range;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] weight;
        sign_case_t                kase;
        logic [STEP_W-1:0]         step;
        logic signed [VALUE_W-1:0] change;
        logic signed [VALUE_W-1:0] next_grad;
    } dec_stage_t;

    typedef struct packed {
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] weight;
        logic signed [VALUE_W-1:0] change;
        logic [STEP_W-1:0]         step;
        sign_case_t                kase;
    } result_t;

    localparam logic [STEP_W-1:0]         STEP_SAT   = '1;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};

    entry_t               entry_mem [MEM_DEPTH];
    entry_t               rd_data_reg;
    entry_t               rd_entry;
    entry_t               wr_entry;

    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic                 s3_valid_reg;
    logic                 res_valid_reg;
    item_t                s1_item_reg;
    mul_stage_t           s2_reg;
    mul_stage_t           s2_next;
    dec_stage_t           s3_reg;
    dec_stage_t           s3_next;
    result_t              res_reg;
    result_t              res_next;

    logic                 advance;
    logic                 hazard;
    logic                 do_pop;
    logic                 do_write;

    logic [PRODUCT_W-1:0] prod_mag;
    logic                 prod_zero;
    logic                 prod_pos;
    logic [SCALED_W-ETA_FRAC-1:0] inc_scaled;
    logic [SCALED_W-ETA_FRAC-1:0] dec_scaled;
    logic [STEP_W-1:0]    inc_step;
    logic [STEP_W-1:0]    dec_step;
    logic [STEP_W-1:0]    grown_step;
    logic [STEP_W-1:0]    shrunk_step;
    logic [STEP_W-1:0]    move_step;
    logic signed [VALUE_W-1:0] move_change;
    logic signed [VALUE_W-1:0] undo_change;
    logic signed [VALUE_W:0]   weight_sum;
    logic signed [VALUE_W-1:0] weight_sat;

    // The whole back pipeline moves when the result register can take a result.
    assign advance = !res_valid_reg || result_ready;

    // An entry still being modified further down must be written before it is read.
    assign hazard = (s1_valid_reg && (s1_item_reg.index == pop_item.index))
                 || (s2_valid_reg && (s2_reg.item.index == pop_item.index))
                 || (s3_valid_reg && (s3_reg.index == pop_item.index));
    assign pop_ready = advance && !hazard;
    assign do_pop    = pop_valid && pop_ready;
    assign do_write  = advance && s3_valid_reg && s3_reg.in_range;

    // Entry table: read when a request is popped, written as it leaves the last stage.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            entry_mem[s3_reg.index[ADDR_W-1:0]] <= wr_entry;
        end
        if (do_pop)
        begin
            rd_data_reg <= entry_mem[pop_item.index[ADDR_W-1:0]];
        end
    end

    // Stage one: gradient product and both scaled steps.
    assign rd_entry = s1_item_reg.in_range ? rd_data_reg : '0;

    always_comb
    begin
        s2_next.item         = s1_item_reg;
        s2_next.weight       = rd_entry.weight;
        s2_next.step         = rd_entry.step;
        s2_next.prior_change = rd_entry.prior_change;
        s2_next.product      = PRODUCT_W'(s1_item_reg.value) * PRODUCT_W'(rd_entry.prior_grad);
        s2_next.inc_prod     = SCALED_W'(rd_entry.step) * SCALED_W'(cfg.eta_increase);
        s2_next.dec_prod     = SCALED_W'(rd_entry.step) * SCALED_W'(cfg.eta_decrease);
    end

    // Stage two: sign case, new step and the change to apply.
    assign prod_mag  = s2_reg.product[PRODUCT_W-1] ? PRODUCT_W'(-s2_reg.product)
                                                   : PRODUCT_W'(s2_reg.product);
    assign prod_zero = prod_mag < PRODUCT_W'(cfg.product_zero_band);
    assign prod_pos  = !s2_reg.product[PRODUCT_W-1] && (s2_reg.product != '0);

    assign inc_scaled  = s2_reg.inc_prod[SCALED_W-1:ETA_FRAC];
    assign dec_scaled  = s2_reg.dec_prod[SCALED_W-1:ETA_FRAC];
    assign inc_step    = (inc_scaled > (SCALED_W-ETA_FRAC)'(STEP_SAT)) ? STEP_SAT
                                                                       : inc_scaled[STEP_W-1:0];
    assign dec_step    = (dec_scaled > (SCALED_W-ETA_FRAC)'(STEP_SAT)) ? STEP_SAT
                                                                       : dec_scaled[STEP_W-1:0];
    assign grown_step  = (inc_step > cfg.step_max) ? cfg.step_max : inc_step;
    assign shrunk_step = (dec_step < cfg.step_min) ? cfg.step_min : dec_step;
    assign move_step   = prod_zero ? s2_reg.step : grown_step;

    always_comb
    begin
        case (s2_reg.item.gsign)
            GS_POS:  move_change = {1'b0, move_step};
            GS_NEG:  move_change = -{1'b0, move_step};
            default: move_change = '0;
        endcase
    end

    // Undoing the most negative change cannot be represented and saturates.
    assign undo_change = (s2_reg.prior_change == VALUE_MIN) ? VALUE_MAX : -s2_reg.prior_change;

    always_comb
    begin
        s3_next.opcode   = s2_reg.item.opcode;
        s3_next.index    = s2_reg.item.index;
        s3_next.in_range = s2_reg.item.in_range;
        s3_next.value    = s2_reg.item.value;
        s3_next.weight   = s2_reg.weight;
        if (s2_reg.item.opcode == OP_LOAD)
        begin
            s3_next.kase      = CASE_LOAD;
            s3_next.step      = cfg.initial_step;
            s3_next.change    = '0;
            s3_next.next_grad = '0;
        end
        else if (prod_zero)
        begin
            s3_next.kase      = CASE_ZERO;
            s3_next.step      = s2_reg.step;
            s3_next.change    = move_change;
            s3_next.next_grad = s2_reg.item.value;
        end
        else if (prod_pos)
        begin
            s3_next.kase      = CASE_SAME;
            s3_next.step      = grown_step;
            s3_next.change    = move_change;
            s3_next.next_grad = s2_reg.item.value;
        end
        else
        begin
            s3_next.kase      = CASE_FLIP;
            s3_next.step      = shrunk_step;
            s3_next.change    = undo_change;
            s3_next.next_grad = '0;
        end
    end

    // Stage three: saturating weight add, table write and result.
    assign weight_sum = (VALUE_W+1)'(s3_reg.weight) + (VALUE_W+1)'(s3_reg.change);

    always_comb
    begin
        if (weight_sum[VALUE_W] != weight_sum[VALUE_W-1])
        begin
            weight_sat = weight_sum[VALUE_W] ? VALUE_MIN : VALUE_MAX;
        end
        else
        begin
            weight_sat = weight_sum[VALUE_W-1:0];
        end
    end

    always_comb
    begin
        res_next.index  = s3_reg.index;
        res_next.weight = (s3_reg.opcode == OP_LOAD) ? s3_reg.value : weight_sat;
        res_next.change = s3_reg.change;
        res_next.step   = s3_reg.step;
        res_next.kase   = s3_reg.kase;
    end

    always_comb
    begin
        wr_entry.weight       = res_next.weight;
        wr_entry.step         = s3_reg.step;
        wr_entry.prior_grad   = s3_reg.next_grad;
        wr_entry.prior_change = s3_reg.change;
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= do_pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            res_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg <= pop_item;
            s2_reg      <= s2_next;
            s3_reg      <= s3_next;
            res_reg     <= res_next;
        end
    end

    assign result_valid  = res_valid_reg;
    assign result_index  = res_reg.index;
    assign new_weight    = res_reg.weight;
    assign weight_change = res_reg.change;
    assign new_step      = res_reg.step;
    assign sign_case     = res_reg.kase;

endmodule
